/* src/cmm_pkg.sv */
package cmm_pkg;

    // default matrix dimension and fixed field widths
    localparam int DefaultDim = 4;
    localparam int DataW      = 32;
    localparam int CoordW     = 3;

    typedef logic signed [DataW-1:0] t_data;
    typedef logic [CoordW-1:0]       t_coord;

    // controller to datapath commands
    typedef struct packed {
        logic   wr_en;
        logic   rd_en;
        logic   last;
        t_coord row;
        t_coord col;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic adv;
    } t_dp_stat;

endpackage

/* src/cmm_in_if.sv */
interface cmm_in_if;
    import cmm_pkg::*;

    logic  valid;
    logic  ready;
    t_data a_value;
    t_data b_value;

    modport source (output valid, output a_value, output b_value, input ready);
    modport sink (input valid, input a_value, input b_value, output ready);
endinterface

/* src/cmm_out_if.sv */
interface cmm_out_if;
    import cmm_pkg::*;

    logic   valid;
    logic   ready;
    t_data  c_value;
    t_coord out_row;
    t_coord out_col;
    logic   last;

    modport source (output valid, output c_value, output out_row, output out_col,
                    output last, input ready);
    modport sink (input valid, input c_value, input out_row, input out_col,
                  input last, output ready);
endinterface

/* src/cmm_ctrl.sv */
module cmm_ctrl #(
    parameter int DIM = cmm_pkg::DefaultDim
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cmm_pkg::t_dp_stat i_stat,
    output cmm_pkg::t_dp_cmd  o_cmd
);
    import cmm_pkg::*;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam t_coord LastIdx = CoordW'(DIM - 1);

    logic   r_state, n_state;
    t_coord r_row, n_row;
    t_coord r_col, n_col;
    logic   at_end;
    logic   step;

    // position walk shared by loading and result issue
    assign at_end     = (r_row == LastIdx) && (r_col == LastIdx);
    assign o_in_ready = (r_state == ST_LOAD);
    assign step       = (r_state == ST_LOAD) ? i_in_valid : i_stat.adv;

    // commands
    always_comb begin
        o_cmd.wr_en = (r_state == ST_LOAD) && i_in_valid;
        o_cmd.rd_en = (r_state == ST_RUN) && i_stat.adv;
        o_cmd.last  = at_end;
        o_cmd.row   = r_row;
        o_cmd.col   = r_col;
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        if (step) begin
            if (at_end) begin
                n_row   = '0;
                n_col   = '0;
                n_state = (r_state == ST_LOAD) ? ST_RUN : ST_LOAD;
            end else if (r_col == LastIdx) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end
endmodule

/* src/cmm_datapath.sv */
module cmm_datapath #(
    parameter int DIM = cmm_pkg::DefaultDim
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmm_pkg::t_dp_cmd  i_cmd,
    input  cmm_pkg::t_data    i_a_value,
    input  cmm_pkg::t_data    i_b_value,
    output cmm_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cmm_pkg::t_data    o_c_value,
    output cmm_pkg::t_coord   o_out_row,
    output cmm_pkg::t_coord   o_out_col,
    output logic              o_out_last
);
    import cmm_pkg::*;

    localparam int RowW = (DIM > 1) ? $clog2(DIM) : 1;

    logic adv;

    // read stage
    logic             r_v1;
    logic [DataW-1:0] r_a_rd [DIM];
    logic [DataW-1:0] r_b_rd [DIM];
    t_coord           r_row1, r_col1;
    logic             r_last1;

    // product stage
    logic             r_v2;
    logic [DataW-1:0] r_prod [DIM];
    t_coord           r_row2, r_col2;
    logic             r_last2;

    // output register
    logic             r_v3;
    logic [DataW-1:0] r_sum;
    t_coord           r_row3, r_col3;
    logic             r_last3;

    logic [DataW-1:0] dot_sum;

    // whole pipeline moves when the output register is free or taken
    assign adv          = !r_v3 || i_out_ready;
    assign o_stat.adv   = adv;

    // one lane per inner index: A banked by column, B banked by row
    for (genvar k = 0; k < DIM; k++) begin : g_lane
        logic [DataW-1:0] r_a_mem [DIM];
        logic [DataW-1:0] r_b_mem [DIM];

        always_ff @(posedge i_clk) begin
            if (i_cmd.wr_en && (i_cmd.col == CoordW'(k))) begin
                r_a_mem[i_cmd.row[RowW-1:0]] <= i_a_value;
            end
            if (i_cmd.wr_en && (i_cmd.row == CoordW'(k))) begin
                r_b_mem[i_cmd.col[RowW-1:0]] <= i_b_value;
            end
            if (i_cmd.rd_en) begin
                r_a_rd[k] <= r_a_mem[i_cmd.row[RowW-1:0]];
                r_b_rd[k] <= r_b_mem[i_cmd.col[RowW-1:0]];
            end
        end

        // low half of the product is the same for signed and unsigned
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_prod[k] <= r_a_rd[k] * r_b_rd[k];
            end
        end
    end

    // dot product over the lanes, wrapping
    always_comb begin
        dot_sum = '0;
        for (int k = 0; k < DIM; k++) begin
            dot_sum = dot_sum + r_prod[k];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // tags and sum
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_row1  <= i_cmd.row;
            r_col1  <= i_cmd.col;
            r_last1 <= i_cmd.last;
            r_row2  <= r_row1;
            r_col2  <= r_col1;
            r_last2 <= r_last1;
            r_row3  <= r_row2;
            r_col3  <= r_col2;
            r_last3 <= r_last2;
            r_sum   <= dot_sum;
        end
    end

    assign o_out_valid = r_v3;
    assign o_c_value   = r_sum;
    assign o_out_row   = r_row3;
    assign o_out_col   = r_col3;
    assign o_out_last  = r_last3;
endmodule

/* src/cannon_matrix_multiply_unit.sv */
// DIM x DIM integer matrix multiply, C = A*B, wrapping modulo 2^32. Each input
// request carries A and B at the same position, row-major; one request is taken
// per cycle while the source offers one. After the last pair the unit issues
// one result per cycle, while the output does not stall, through DIM parallel
// multipliers, a lane adder and a three-stage pipeline, then C leaves row-major
// with last set on the final element. Input is refused while results are
// issued, and an output stall stalls the issue. The next batch may load while
// the tail of the previous one drains.
module cannon_matrix_multiply_unit #(
    parameter int DIM = cmm_pkg::DefaultDim
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cmm_in_if.sink   i_in,
    cmm_out_if.source o_out
);
    import cmm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cmm_ctrl #(.DIM(DIM)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cmm_datapath #(.DIM(DIM)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_a_value   (i_in.a_value),
        .i_b_value   (i_in.b_value),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_c_value   (o_out.c_value),
        .o_out_row   (o_out.out_row),
        .o_out_col   (o_out.out_col),
        .o_out_last  (o_out.last)
    );
endmodule

/* sim/tb_cannon_matrix_multiply_unit.sv */
module tb_cannon_matrix_multiply_unit;
    import cmm_pkg::*;

    localparam int Dim   = DefaultDim;
    localparam int Cells = Dim * Dim;

    // random part: 7 requests finish the second batch, then whole batches
    localparam int RandReqs  = 7 + 26 * Cells;
    localparam int CalmFrom  = RandReqs - 5 * Cells;
    localparam int HoldAt    = 40;
    localparam int HoldLen   = 300;
    localparam int DrainWait = 2 * Cells + 8;
    localparam int MaxReport = 100;

    typedef enum int {FillRandom, FillSmall, FillExtreme, FillMixed} t_fill;

    typedef struct {
        t_data a;
        t_data b;
        bit    known;
        t_data c_exp;
    } t_stim_row;

    typedef struct {
        t_data  c;
        t_coord row;
        t_coord col;
        logic   last;
    } t_c_elem;

    logic i_clk;
    logic i_rst_n;

    cmm_in_if  in_ch ();
    cmm_out_if out_ch ();

    cannon_matrix_multiply_unit #(.DIM(Dim)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // directed requests: first batch has A = identity, so C equals B
    t_stim_row stim_tab [0:24] = '{
        '{32'sd1, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF},
        '{32'sd0, 32'sh8000_0000, 1'b1, 32'sh8000_0000},
        '{32'sd0, 32'shFFFF_FFFF, 1'b1, 32'shFFFF_FFFF},
        '{32'sd0, 32'sh0000_0000, 1'b1, 32'sh0000_0000},
        '{32'sd0, 32'sh0000_0001, 1'b1, 32'sh0000_0001},
        '{32'sd1, 32'sh5555_5555, 1'b1, 32'sh5555_5555},
        '{32'sd0, 32'shAAAA_AAAA, 1'b1, 32'shAAAA_AAAA},
        '{32'sd0, 32'sh0000_FFFF, 1'b1, 32'sh0000_FFFF},
        '{32'sd0, 32'shFFFF_0000, 1'b1, 32'shFFFF_0000},
        '{32'sd0, 32'sh8000_0001, 1'b1, 32'sh8000_0001},
        '{32'sd1, 32'sh7FFF_FFFE, 1'b1, 32'sh7FFF_FFFE},
        '{32'sd0, 32'sh0F0F_0F0F, 1'b1, 32'sh0F0F_0F0F},
        '{32'sd0, 32'shF0F0_F0F0, 1'b1, 32'shF0F0_F0F0},
        '{32'sd0, 32'sh0000_0002, 1'b1, 32'sh0000_0002},
        '{32'sd0, 32'shFFFF_FFFE, 1'b1, 32'shFFFF_FFFE},
        '{32'sd1, 32'sh3C3C_3C3C, 1'b1, 32'sh3C3C_3C3C},
        // overflow of products and sums, rest of the batch is random
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
        '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sd0},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
        '{32'shFFFF_FFFF, 32'sh8000_0000, 1'b0, 32'sd0},
        '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0, 32'sd0},
        '{32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b0, 32'sd0},
        '{32'sh8000_0000, 32'sh0000_0001, 1'b0, 32'sd0},
        '{32'sh0001_0000, 32'sh0001_0000, 1'b0, 32'sd0},
        '{32'sh0000_FFFF, 32'sh0000_FFFF, 1'b0, 32'sd0}
    };

    // predictor state
    t_data   a_mat [Cells];
    t_data   b_mat [Cells];
    t_data   typed_c [Cells];
    bit      typed_ok [Cells];
    int      load_pos;
    t_c_elem c_pending [$];

    int n_err;
    int n_recv;
    bit calm;
    bit src_bursty;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #500000;
        $display("** cannon_matrix_multiply_unit: FAILED **");
        $finish;
    end

    // C = A*B by skew, then Dim rounds of multiply-accumulate and one-place shift
    function automatic void cannon_product();
        logic [DataW-1:0] sa [Cells];
        logic [DataW-1:0] sb [Cells];
        logic [DataW-1:0] ta [Cells];
        logic [DataW-1:0] tb [Cells];
        logic [DataW-1:0] acc [Cells];
        t_c_elem e;
        int r, c, t, k;
        for (r = 0; r < Dim; r++) begin
            for (c = 0; c < Dim; c++) begin
                sa[r*Dim + c]  = a_mat[r*Dim + (c + r) % Dim];
                sb[r*Dim + c]  = b_mat[((r + c) % Dim)*Dim + c];
                acc[r*Dim + c] = '0;
            end
        end
        for (t = 0; t < Dim; t++) begin
            for (k = 0; k < Cells; k++) begin
                acc[k] = acc[k] + sa[k] * sb[k];
            end
            for (r = 0; r < Dim; r++) begin
                for (c = 0; c < Dim; c++) begin
                    ta[r*Dim + c] = sa[r*Dim + (c + 1) % Dim];
                    tb[r*Dim + c] = sb[((r + 1) % Dim)*Dim + c];
                end
            end
            sa = ta;
            sb = tb;
        end
        // results leave row-major, last on the final element
        for (k = 0; k < Cells; k++) begin
            e.c    = typed_ok[k] ? typed_c[k] : t_data'(acc[k]);
            e.row  = t_coord'(k / Dim);
            e.col  = t_coord'(k % Dim);
            e.last = (k == Cells - 1);
            c_pending.push_back(e);
            typed_ok[k] = 1'b0;
        end
    endfunction

    // store one accepted pair, compute C when the batch is complete
    function automatic void load_pair(t_data a, t_data b, bit known, t_data c_exp);
        a_mat[load_pos] = a;
        b_mat[load_pos] = b;
        if (known) begin
            typed_c[load_pos]  = c_exp;
            typed_ok[load_pos] = 1'b1;
        end
        if (load_pos == Cells - 1) begin
            load_pos = 0;
            cannon_product();
        end else begin
            load_pos++;
        end
    endfunction

    function automatic t_data pick_word(t_fill fill);
        t_fill f;
        f = (fill == FillMixed) ? t_fill'($urandom_range(0, 2)) : fill;
        case (f)
            FillSmall: return t_data'(int'($urandom_range(0, 16)) - 8);
            FillExtreme: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'shFFFF_FFFF;
                    3: return 32'sh0000_0000;
                    4: return 32'sh0000_0001;
                    default: return 32'sh8000_0001;
                endcase
            end
            default: return t_data'($urandom);
        endcase
    endfunction

    // offer one request, with an occasional gap in front of it
    task automatic offer_pair(input t_data a, input t_data b, input bit known,
                              input t_data c_exp);
        int gap;
        gap = 0;
        if (!calm && src_bursty && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 7);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid   <= 1'b1;
        in_ch.a_value <= a;
        in_ch.b_value <= b;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        load_pair(a, b, known, c_exp);
    endtask

    function automatic void field_check(string fname, longint expv, longint actv);
        if (expv != actv) begin
            n_err++;
            if (n_err <= MaxReport)
                $error("%s: expected %0d, actual %0d", fname, expv, actv);
        end
    endfunction

    // result receiver: random stalls, one long hold-off, none near the end
    initial begin : result_sink
        int stall_left;
        bit sink_bursty;
        bit held;
        stall_left   = 0;
        sink_bursty  = 1'b1;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_recv >= HoldAt) begin
                // long hold-off so the block fills and refuses requests
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HoldLen) @(negedge i_clk);
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (!calm && sink_bursty && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 7) - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
                sink_bursty = !sink_bursty;
        end
    end

    // compare each accepted result with the oldest expected element
    always @(posedge i_clk) begin : check_results
        t_c_elem want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            n_recv++;
            if (c_pending.size() == 0) begin
                n_err++;
                if (n_err <= MaxReport)
                    $error("unexpected result: c_value %0d at (%0d,%0d)",
                           out_ch.c_value, out_ch.out_row, out_ch.out_col);
            end else begin
                want = c_pending.pop_front();
                field_check("c_value", want.c, out_ch.c_value);
                field_check("out_row", want.row, out_ch.out_row);
                field_check("out_col", want.col, out_ch.out_col);
                field_check("last", want.last, out_ch.last);
            end
        end
    end

    // reset, directed table, random batches, drain
    initial begin : stimulus
        int    m;
        t_fill fill;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.a_value = '0;
        in_ch.b_value = '0;
        load_pos      = 0;
        n_err         = 0;
        n_recv        = 0;
        calm          = 1'b0;
        src_bursty    = 1'b1;
        fill          = FillRandom;
        foreach (typed_ok[k]) typed_ok[k] = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_tab[i])
            offer_pair(stim_tab[i].a, stim_tab[i].b, stim_tab[i].known, stim_tab[i].c_exp);

        for (m = 0; m < RandReqs; m++) begin
            if (load_pos == 0) begin
                fill       = t_fill'($urandom_range(0, 3));
                src_bursty = ($urandom_range(0, 2) != 0);
            end
            if (m >= CalmFrom)
                calm = 1'b1;
            offer_pair(pick_word(fill), pick_word(fill), 1'b0, '0);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        while (c_pending.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (n_err == 0) begin
            $display("** cannon_matrix_multiply_unit: PASSED **");
        end else begin
            $display("** cannon_matrix_multiply_unit: FAILED **");
        end
        $finish;
    end

endmodule
